>>> sv/atrp_pkg.sv
// Package for the accelerometer tilt block: payload types, CORDIC table, helpers.
// No dependencies.
package atrp_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int INT_FRAC        = 16;
    localparam int SQ_STEPS        = 32;
    localparam int CW              = 44;   // CORDIC datapath width, signed
    localparam int AW              = 25;   // angle accumulator width, signed
    localparam int NW              = 41;   // normalized top bit index is 40

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } in_t;

    typedef struct packed {
        logic signed [15:0] roll_deg;
        logic signed [15:0] pitch_deg;
    } out_t;

    function automatic logic signed [AW-1:0] atan_q16(input int i);
        logic signed [AW-1:0] r;
        begin
            case (i)
                0: r = 25'sd2949120;
                1: r = 25'sd1740967;
                2: r = 25'sd919879;
                3: r = 25'sd466945;
                4: r = 25'sd234379;
                5: r = 25'sd117304;
                6: r = 25'sd58666;
                7: r = 25'sd29335;
                8: r = 25'sd14668;
                9: r = 25'sd7334;
                10: r = 25'sd3667;
                11: r = 25'sd1833;
                12: r = 25'sd917;
                13: r = 25'sd458;
                14: r = 25'sd229;
                15: r = 25'sd115;
                16: r = 25'sd57;
                17: r = 25'sd29;
                18: r = 25'sd14;
                19: r = 25'sd7;
                20: r = 25'sd4;
                21: r = 25'sd2;
                22: r = 25'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> sv/atrp_sqrt.sv
// Pipelined floor square root of (a*a + b*b) * 2^32: squares stage, sum stage, then one
// restoring step per stage. Outputs the root with 16 fraction bits.
// Depends on atrp_pkg.
module atrp_sqrt (
    input  logic                clk,
    input  logic                en,
    input  logic signed [16:0]  a,
    input  logic signed [16:0]  b,
    output logic [31:0]         root
);
    import atrp_pkg::*;

    logic [63:0] rem_reg [0:SQ_STEPS];
    logic [63:0] res_reg [0:SQ_STEPS];
    logic [33:0] aa_reg;
    logic [33:0] bb_reg;

    // stage 0: squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aa_reg <= 34'(a * a);
            bb_reg <= 34'(b * b);
        end
    end

    // sum of squares reaches 2^31, needs the full 32 bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {32'(aa_reg + bb_reg), 32'd0};
            res_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;
        assign trial = res_reg[k] + BIT;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[k] >= trial)
                begin
                    rem_reg[k+1] <= rem_reg[k] - trial;
                    res_reg[k+1] <= (res_reg[k] >> 1) + BIT;
                end
                else
                begin
                    rem_reg[k+1] <= rem_reg[k];
                    res_reg[k+1] <= res_reg[k] >> 1;
                end
            end
        end
    end

    assign root = res_reg[SQ_STEPS][31:0];
endmodule

>>> sv/atrp_atan.sv
// Pipelined atan2(num, root): normalize, CORDIC_STEPS vectoring stages, round/clamp.
// Depends on atrp_pkg.
module atrp_atan (
    input  logic                clk,
    input  logic                en,
    input  logic signed [16:0]  num,
    input  logic [31:0]         root,
    output logic signed [15:0]  angle
);
    import atrp_pkg::*;

    logic signed [CW-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [AW-1:0] z_reg [0:CORDIC_STEPS];
    logic                 zero_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] xi_reg;
    logic signed [CW-1:0] yi_reg;
    logic [5:0]           sh_reg;
    logic                 zi_reg;

    logic signed [CW-1:0] xv;
    logic signed [CW-1:0] yv;
    logic [CW-1:0]        mx;
    logic [5:0]           sh;

    // stage A: magnitude and leading-one position
    always_comb
    begin
        xv = CW'(signed'({1'b0, root}));
        yv = CW'(num) <<< 16;
        mx = (yv < 0) ? CW'(-yv) : CW'(yv);
        if (CW'(xv) > mx)
            mx = CW'(xv);
        sh = '0;
        // highest set bit wins, scanned upward
        for (int i = 0; i < NW; i++)
        begin
            if (mx[i])
                sh = 6'(NW - 1 - i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xi_reg <= xv;
            yi_reg <= yv;
            sh_reg <= sh;
            zi_reg <= (mx == '0);
        end
    end

    // stage B: shift
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= xi_reg <<< sh_reg;
            y_reg[0]    <= yi_reg <<< sh_reg;
            z_reg[0]    <= '0;
            zero_reg[0] <= zi_reg;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        localparam logic signed [AW-1:0] ATAN = atan_q16(i);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
            end
        end
    end

    // final: round half away, clamp to 90 deg
    localparam int SH = INT_FRAC - ANGLE_FRAC_BITS;
    localparam logic [AW-1:0] LIM = AW'(90) << ANGLE_FRAC_BITS;
    logic signed [AW-1:0] ang;
    logic [AW-1:0]        mag;
    logic signed [15:0]   res;
    logic signed [15:0]   angle_reg;

    always_comb
    begin
        ang = z_reg[CORDIC_STEPS];
        mag = (ang < 0) ? AW'(-ang) : AW'(ang);
        if (SH > 0)
            mag = (mag + (AW'(1) << (SH - 1))) >> SH;
        if (mag > LIM)
            mag = LIM;
        if (ang < 0)
            res = (mag > AW'(32768)) ? 16'sh8000 : 16'(-mag);
        else
            res = (mag > AW'(32767)) ? 16'sh7fff : 16'(mag);
        if (zero_reg[CORDIC_STEPS])
            res = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= res;
    end

    assign angle = angle_reg;
endmodule

>>> sv/accel_tilt_roll_pitch.sv
// Accelerometer tilt: roll and pitch from one sample per cycle while not stalled.
// Pipeline order: sqrt squares and sum, sqrt steps, normalize and shift, CORDIC stages, output register.
// Throughput: one request per cycle unless stalled; the sqrt steps and CORDIC stages set the depth.
// A stall freezes the whole pipe; the valid shift line is the only reset state.
// Reset (rst_n, async, active low) clears valid bits only.
module accel_tilt_roll_pitch (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  atrp_pkg::in_t     in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output atrp_pkg::out_t    out_data
);
    import atrp_pkg::*;

    localparam int DEPTH = 2 + SQ_STEPS + 2 + CORDIC_STEPS + 1;

    // Whole-pipe enable: advance unless a valid result sits stalled at the output.
    logic en;
    logic [DEPTH-1:0] vld_reg;
    assign en       = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    // Numerators lag the square-root pipe by its depth.
    logic signed [16:0] ny_reg [0:SQ_STEPS+1];
    logic signed [16:0] nx_reg [0:SQ_STEPS+1];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ny_reg[0] <= 17'(in_data.accel_y);
            nx_reg[0] <= -17'(in_data.accel_x);
            for (int k = 1; k <= SQ_STEPS + 1; k++)
            begin
                ny_reg[k] <= ny_reg[k-1];
                nx_reg[k] <= nx_reg[k-1];
            end
        end
    end

    logic [31:0] root_r;
    logic [31:0] root_p;

    atrp_sqrt u_sqrt_r (
        .clk (clk), .en (en),
        .a (17'(in_data.accel_x)), .b (17'(in_data.accel_z)), .root (root_r)
    );
    atrp_sqrt u_sqrt_p (
        .clk (clk), .en (en),
        .a (17'(in_data.accel_y)), .b (17'(in_data.accel_z)), .root (root_p)
    );

    logic signed [15:0] roll;
    logic signed [15:0] pitch;

    atrp_atan u_atan_r (
        .clk (clk), .en (en), .num (ny_reg[SQ_STEPS+1]), .root (root_r), .angle (roll)
    );
    atrp_atan u_atan_p (
        .clk (clk), .en (en), .num (nx_reg[SQ_STEPS+1]), .root (root_p), .angle (pitch)
    );

    assign out_valid          = vld_reg[DEPTH-1];
    assign out_data.roll_deg  = roll;
    assign out_data.pitch_deg = pitch;

`ifndef NO_ASSERTIONS
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed under stall");
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall mismatch");
    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.roll_deg <= 16'sd23040 && out_data.roll_deg >= -16'sd23040))
        else $error("roll out of range");
`endif
endmodule

>>> verif/accel_tilt_roll_pitch_tb.sv
// Testbench for accel_tilt_roll_pitch: directed and random acceleration samples,
// roll/pitch predicted bit-exact in the bench, compared in order. Needs atrp_pkg.
module accel_tilt_roll_pitch_tb;
    import atrp_pkg::*;

    localparam int LATENCY     = 2 + SQ_STEPS + 2 + CORDIC_STEPS + 1;
    localparam int NUM_RANDOM  = 1750;
    localparam int WATCHDOG    = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_t  in_data;
    logic out_valid;
    logic out_stall;
    out_t out_data;

    in_t  sample_q[$];     // samples waiting to be offered
    out_t angle_q[$];      // expected angles, oldest first
    int   n_errors;
    int   idle_cycles;
    bit   stim_done;
    bit   quiet_in;        // no idling stretch, sender side
    bit   quiet_out;       // no idling stretch, receiver side
    bit   hold_req;        // receiver long hold-off request
    int   hold_left;
    bit   in_taken;        // request accepted at the last rising edge

    accel_tilt_roll_pitch DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor square root of a 64-bit value, bit-serial
    function automatic longint unsigned sqrt_floor(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        longint unsigned rem;
        res = 0;
        b   = 64'd1 << 62;
        rem = v;
        for (int k = 0; k < 32; k++)
        begin
            if (rem >= res + b)
            begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // atan2(num, sqrt(a^2 + b^2)) in degrees, ANGLE_FRAC_BITS fraction bits
    function automatic logic signed [15:0] tilt_angle(input longint num, input longint a,
                                                       input longint b);
        longint unsigned sq;
        longint xv;
        longint yv;
        longint mx;
        longint ang;
        longint mag;
        longint lim;
        longint dx;
        longint dy;
        longint res;
        int     sh;
        sq  = longint'(a * a) + longint'(b * b);
        xv  = longint'(sqrt_floor(sq << 32));
        yv  = num * 65536;
        ang = 0;
        sh  = INT_FRAC - ANGLE_FRAC_BITS;
        mx  = (yv < 0) ? -yv : yv;
        if (xv > mx)
            mx = xv;
        if (mx == 0)
            return '0;
        // normalize so the larger operand reaches 2^40
        while (mx < (64'sd1 <<< 40))
        begin
            xv = xv * 2;
            yv = yv * 2;
            mx = mx * 2;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = yv >>> i;   // arithmetic shift is floor division
            dy = xv >>> i;
            if (yv >= 0)
            begin
                xv  = xv + dx;
                yv  = yv - dy;
                ang = ang + longint'(atan_q16(i));
            end
            else
            begin
                xv  = xv - dx;
                yv  = yv + dy;
                ang = ang - longint'(atan_q16(i));
            end
        end
        mag = (ang < 0) ? -ang : ang;
        if (sh > 0)
            mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
        lim = 64'sd90 <<< ANGLE_FRAC_BITS;
        if (mag > lim)
            mag = lim;
        if (ang < 0)
        begin
            if (mag > 32768)
                mag = 32768;
            res = -mag;
        end
        else
        begin
            if (mag > 32767)
                mag = 32767;
            res = mag;
        end
        return res[15:0];
    endfunction

    function automatic out_t predict_tilt(input in_t s);
        out_t   r;
        longint x;
        longint y;
        longint z;
        x = longint'(s.accel_x);
        y = longint'(s.accel_y);
        z = longint'(s.accel_z);
        r.roll_deg  = tilt_angle(y, x, z);
        r.pitch_deg = tilt_angle(-x, y, z);
        return r;
    endfunction

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(0, 16)) - 8);
            3: return 16'($signed($urandom_range(0, 600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_sample(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] z);
        in_t s;
        s.accel_x = x;
        s.accel_y = y;
        s.accel_z = z;
        sample_q.push_back(s);
    endtask

    // Stimulus: directed corners, then random samples
    initial
    begin
        rst_n     = 1'b0;
        stim_done = 1'b0;
        quiet_in  = 1'b0;
        quiet_out = 1'b0;
        hold_req  = 1'b0;
        // all zero, pure axes, extremes, most negative X, unit values, mixed patterns
        add_sample(16'h0000, 16'h0000, 16'h0000);
        add_sample(16'h0000, 16'h0000, 16'h7FFF);
        add_sample(16'h0000, 16'h0000, 16'h8000);
        add_sample(16'h7FFF, 16'h0000, 16'h0000);   // zero root on pitch side
        add_sample(16'h8000, 16'h0000, 16'h0000);
        add_sample(16'h0000, 16'h7FFF, 16'h0000);
        add_sample(16'h0000, 16'h8000, 16'h0000);
        add_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        add_sample(16'h8000, 16'h8000, 16'h8000);
        add_sample(16'h8000, 16'h7FFF, 16'h0000);
        add_sample(16'h7FFF, 16'h8000, 16'h8000);
        add_sample(16'h0001, 16'h0000, 16'h0000);
        add_sample(16'hFFFF, 16'h0000, 16'h0000);
        add_sample(16'h0000, 16'h0001, 16'h0000);
        add_sample(16'h0000, 16'hFFFF, 16'h0000);
        add_sample(16'h0001, 16'h0001, 16'h0001);
        add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_sample(16'h0100, 16'hFF00, 16'h4000);
        add_sample(16'h5555, 16'hAAAA, 16'h5555);
        add_sample(16'hAAAA, 16'h5555, 16'hAAAA);
        for (int i = 0; i < NUM_RANDOM; i++)
            add_sample(rand_axis(), rand_axis(), rand_axis());
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // long stretch with no idling on either side
        wait (sample_q.size() < NUM_RANDOM - 200);
        quiet_in  = 1'b1;
        quiet_out = 1'b1;
        wait (sample_q.size() < NUM_RANDOM - 500);
        quiet_in  = 1'b0;
        quiet_out = 1'b0;
        // receiver holds off while sender keeps offering: pipe fills, input stalls
        hold_req = 1'b1;
        wait (sample_q.size() < NUM_RANDOM - 700);
        wait (sample_q.size() == 0 && !in_valid);
        wait (angle_q.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        stim_done = 1'b1;
    end

    // Input accept seen at the rising edge, registered for the driver on the falling edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
            in_taken <= in_valid && !in_stall;
    end

    // Driver: a request is taken on a rising edge with valid high and stall low
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_taken)
        begin
            if (sample_q.size() > 0 && (quiet_in || $urandom_range(0, 99) >= 13))
            begin
                in_valid <= 1'b1;
                in_data  <= sample_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall, with one long hold-off counted here
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b1;
            hold_left <= -1;
        end
        else if (hold_req && hold_left == -1)
        begin
            hold_left <= 300;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !quiet_out && ($urandom_range(0, 99) < 13);
    end

    // Predict on input accept; check on output accept
    always @(posedge clk)
    begin
        out_t exp_a;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                angle_q.push_back(predict_tilt(in_data));
            if (out_valid && !out_stall)
            begin
                if (angle_q.size() == 0)
                begin
                    $error("unexpected result roll_deg=%0d pitch_deg=%0d",
                           out_data.roll_deg, out_data.pitch_deg);
                    n_errors++;
                end
                else
                begin
                    exp_a = angle_q.pop_front();
                    if (out_data.roll_deg !== exp_a.roll_deg)
                    begin
                        $error("roll_deg expected %0d actual %0d",
                               exp_a.roll_deg, out_data.roll_deg);
                        n_errors++;
                    end
                    if (out_data.pitch_deg !== exp_a.pitch_deg)
                    begin
                        $error("pitch_deg expected %0d actual %0d",
                               exp_a.pitch_deg, out_data.pitch_deg);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request or result, and end of run
    initial
    begin
        n_errors    = 0;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (stim_done)
            begin
                if (angle_q.size() != 0)
                    n_errors++;
                if (n_errors == 0)
                    $display("end of test: clean");
                else
                    $display("end of test: mismatches");
                $finish;
            end
            else if (idle_cycles >= WATCHDOG)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule

>>> sim.f
sv/atrp_pkg.sv
sv/atrp_sqrt.sv
sv/atrp_atan.sv
sv/accel_tilt_roll_pitch.sv
verif/accel_tilt_roll_pitch_tb.sv
